// ===== src/scer_pkg.sv =====
package scer_pkg;

   localparam int ITEMS_MAX = 7;
   localparam int CAND_NUM = 6;
   localparam logic [31:0] PERIOD_RESET = 32'd60000000;

   typedef logic [3:0] event_code_type;
   typedef logic [3:0] src_state_type;
   typedef logic [2:0] item_count_type;

   localparam event_code_type EV_BOOT         = 4'd0;
   localparam event_code_type EV_UNCONFIGURED = 4'd1;
   localparam event_code_type EV_INVALID      = 4'd2;
   localparam event_code_type EV_NET_READY    = 4'd3;
   localparam event_code_type EV_ATTEMPT      = 4'd4;
   localparam event_code_type EV_SYNCING      = 4'd5;
   localparam event_code_type EV_TRUSTED      = 4'd6;
   localparam event_code_type EV_REJECTED     = 4'd7;
   localparam event_code_type EV_TIMEOUT      = 4'd8;
   localparam event_code_type EV_ERROR        = 4'd9;
   localparam event_code_type EV_LINK_LOST    = 4'd10;
   localparam event_code_type EV_LINK_READY   = 4'd11;
   localparam event_code_type EV_SUMMARY      = 4'd12;
   localparam event_code_type EV_VIOLATION    = 4'd13;

   localparam src_state_type SRC_UNCONFIGURED   = 4'd0;
   localparam src_state_type SRC_CONFIGURED     = 4'd1;
   localparam src_state_type SRC_START_PENDING  = 4'd2;
   localparam src_state_type SRC_SYNCING        = 4'd3;
   localparam src_state_type SRC_TRUSTED        = 4'd4;
   localparam src_state_type SRC_REJECTED       = 4'd5;
   localparam src_state_type SRC_TIMEOUT        = 4'd6;
   localparam src_state_type SRC_ERROR          = 4'd7;
   localparam src_state_type SRC_STOPPED        = 4'd8;
   localparam src_state_type SRC_INVALID        = 4'd9;
   localparam src_state_type SRC_RESERVED_FIRST = 4'd10;
   localparam src_state_type SRC_RESERVED_LAST  = 4'd15;

   typedef struct packed {
      logic [ITEMS_MAX-1:0][3:0] codes;
      item_count_type            count;
   } tick_desc_type;

   function automatic logic src_has_event(src_state_type src);
      logic r;
      case (src) inside
         SRC_CONFIGURED, SRC_STOPPED:              r = 1'b0;
         [SRC_RESERVED_FIRST:SRC_RESERVED_LAST]:   r = 1'b0;
         default:                                  r = 1'b1;
      endcase
      return r;
   endfunction

   function automatic event_code_type src_event(src_state_type src);
      event_code_type r;
      unique case (src)
         SRC_UNCONFIGURED:  r = EV_UNCONFIGURED;
         SRC_START_PENDING: r = EV_ATTEMPT;
         SRC_SYNCING:       r = EV_SYNCING;
         SRC_TRUSTED:       r = EV_TRUSTED;
         SRC_REJECTED:      r = EV_REJECTED;
         SRC_TIMEOUT:       r = EV_TIMEOUT;
         SRC_ERROR:         r = EV_ERROR;
         SRC_INVALID:       r = EV_INVALID;
         default:           r = EV_BOOT;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] sat_inc32(logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

endpackage

// ===== src/scer_if.sv =====
interface scer_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] time_us;
   logic        net_rdy;
   logic        link_avail;
   logic        link_up;
   logic [7:0]  attempts;
   logic [3:0]  src_state;
   logic [15:0] violation_mask;

   modport source (output valid, time_us, net_rdy, link_avail, link_up, attempts,
                   src_state, violation_mask, input ready);
   modport sink (input valid, time_us, net_rdy, link_avail, link_up, attempts,
                 src_state, violation_mask, output ready);
endinterface

interface scer_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  event_code;
   logic [31:0] summary_sequence;
   logic [31:0] emitted_total;
   logic        last_of_tick;

   modport source (output valid, event_code, summary_sequence, emitted_total, last_of_tick,
                   input ready);
   modport sink (input valid, event_code, summary_sequence, emitted_total, last_of_tick,
                 output ready);
endinterface

interface scer_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] summary_period_us;

   modport source (output valid, summary_period_us, input ready);
   modport sink (input valid, summary_period_us, output ready);
endinterface

// ===== src/scer_front.sv =====
module scer_front #(
   parameter int MAX_EVENTS = 6
) (
   input  logic                   clock,
   input  logic                   reset,
   scer_req_if.sink               req,
   scer_csr_if.sink               csr,
   input  logic                   q_full,
   output logic                   q_push,
   output scer_pkg::tick_desc_type q_desc
);

   logic [31:0] period_ff, period_in;
   logic        boot_done_ff, boot_done_in;
   logic        net_done_ff, net_done_in;
   logic        link_valid_ff, link_valid_in;
   logic        prev_link_up_ff, prev_link_up_in;
   logic [7:0]  prev_att_ff, prev_att_in;
   logic        src_valid_ff, src_valid_in;
   logic [3:0]  prev_src_ff, prev_src_in;
   logic        viol_active_ff, viol_active_in;
   logic [15:0] prev_mask_ff, prev_mask_in;
   logic        started_ff, started_in;
   logic [63:0] anchor_ff, anchor_in;

   logic        accept;
   logic        regress;
   logic [63:0] elapsed;
   logic        due;
   logic [scer_pkg::CAND_NUM-1:0]      cand_hit;
   logic [scer_pkg::CAND_NUM-1:0][3:0] cand_code;
   scer_pkg::item_count_type           n_ev;
   scer_pkg::tick_desc_type            desc;

   assign req.ready = !q_full;
   assign csr.ready = 1'b1;
   assign accept    = req.valid && req.ready;

   assign regress = req.time_us < anchor_ff;
   assign elapsed = req.time_us - anchor_ff;
   assign due     = !started_ff || (!regress && (elapsed >= {32'd0, period_ff}));

   always_comb begin
      cand_hit[0]  = !boot_done_ff;
      cand_code[0] = scer_pkg::EV_BOOT;
      cand_hit[1]  = req.net_rdy && !net_done_ff;
      cand_code[1] = scer_pkg::EV_NET_READY;
      cand_hit[2]  = req.link_avail && (!link_valid_ff || (prev_link_up_ff != req.link_up));
      cand_code[2] = req.link_up ? scer_pkg::EV_LINK_READY : scer_pkg::EV_LINK_LOST;
      cand_hit[3]  = req.attempts > prev_att_ff;
      cand_code[3] = scer_pkg::EV_ATTEMPT;
      cand_hit[4]  = (!src_valid_ff || (prev_src_ff != req.src_state))
                     && scer_pkg::src_has_event(req.src_state);
      cand_code[4] = scer_pkg::src_event(req.src_state);
      cand_hit[5]  = (req.violation_mask != 16'd0)
                     && (!viol_active_ff || (prev_mask_ff != req.violation_mask) || due);
      cand_code[5] = scer_pkg::EV_VIOLATION;
   end

   // pack hits in order, capped, then append the summary when due
   always_comb begin
      desc.codes = '0;
      n_ev = '0;
      for (int i = 0; i < scer_pkg::CAND_NUM; i++) begin
         if (cand_hit[i] && (n_ev < scer_pkg::item_count_type'(MAX_EVENTS))) begin
            desc.codes[n_ev] = cand_code[i];
            n_ev = n_ev + 3'd1;
         end
      end
      if (due) begin
         desc.codes[n_ev] = scer_pkg::EV_SUMMARY;
      end
      desc.count = n_ev + scer_pkg::item_count_type'(due);
   end

   assign q_push = accept && (desc.count != '0);
   assign q_desc = desc;

   always_comb begin
      period_in       = period_ff;
      boot_done_in    = boot_done_ff;
      net_done_in     = net_done_ff;
      link_valid_in   = link_valid_ff;
      prev_link_up_in = prev_link_up_ff;
      prev_att_in     = prev_att_ff;
      src_valid_in    = src_valid_ff;
      prev_src_in     = prev_src_ff;
      viol_active_in  = viol_active_ff;
      prev_mask_in    = prev_mask_ff;
      started_in      = started_ff;
      anchor_in       = anchor_ff;
      if (csr.valid && csr.ready) begin
         period_in = csr.summary_period_us;
      end
      if (accept) begin
         boot_done_in = 1'b1;
         if (req.net_rdy) begin
            net_done_in = 1'b1;
         end
         if (req.link_avail) begin
            link_valid_in   = 1'b1;
            prev_link_up_in = req.link_up;
         end
         prev_att_in    = req.attempts;
         src_valid_in   = 1'b1;
         prev_src_in    = req.src_state;
         viol_active_in = req.violation_mask != 16'd0;
         prev_mask_in   = req.violation_mask;
         if (due || (started_ff && regress)) begin
            anchor_in = req.time_us;
         end
         if (due) begin
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= scer_pkg::PERIOD_RESET;
         boot_done_ff    <= 1'b0;
         net_done_ff     <= 1'b0;
         link_valid_ff   <= 1'b0;
         prev_link_up_ff <= 1'b0;
         prev_att_ff     <= '0;
         src_valid_ff    <= 1'b0;
         prev_src_ff     <= scer_pkg::SRC_UNCONFIGURED;
         viol_active_ff  <= 1'b0;
         prev_mask_ff    <= '0;
         started_ff      <= 1'b0;
         anchor_ff       <= '0;
      end else begin
         period_ff       <= period_in;
         boot_done_ff    <= boot_done_in;
         net_done_ff     <= net_done_in;
         link_valid_ff   <= link_valid_in;
         prev_link_up_ff <= prev_link_up_in;
         prev_att_ff     <= prev_att_in;
         src_valid_ff    <= src_valid_in;
         prev_src_ff     <= prev_src_in;
         viol_active_ff  <= viol_active_in;
         prev_mask_ff    <= prev_mask_in;
         started_ff      <= started_in;
         anchor_ff       <= anchor_in;
      end
   end

endmodule

// ===== src/scer_queue.sv =====
module scer_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  scer_pkg::tick_desc_type push_desc,
   output logic                    full,
   input  logic                    pop,
   output logic                    empty,
   output scer_pkg::tick_desc_type head
);

   scer_pkg::tick_desc_type mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== src/scer_back.sv =====
module scer_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  scer_pkg::tick_desc_type q_head,
   output logic                    q_pop,
   scer_rsp_if.source              rsp
);

   scer_pkg::item_count_type idx_ff, idx_in;
   logic [31:0] emit_total_ff, emit_total_in;
   logic [31:0] sum_count_ff, sum_count_in;
   logic        out_valid_ff, out_valid_in;
   logic [3:0]  code_ff, code_in;
   logic [31:0] seq_ff, seq_in;
   logic [31:0] total_ff, total_in;
   logic        last_ff, last_in;

   logic                     load;
   logic                     last;
   scer_pkg::event_code_type code;

   assign load = !q_empty && (!out_valid_ff || rsp.ready);
   assign last = idx_ff == (q_head.count - 3'd1);
   assign code = q_head.codes[idx_ff];
   assign q_pop = load && last;

   always_comb begin
      idx_in        = idx_ff;
      emit_total_in = emit_total_ff;
      sum_count_in  = sum_count_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      code_in       = code_ff;
      seq_in        = seq_ff;
      total_in      = total_ff;
      last_in       = last_ff;
      if (load) begin
         idx_in        = last ? '0 : idx_ff + 3'd1;
         emit_total_in = scer_pkg::sat_inc32(emit_total_ff);
         out_valid_in  = 1'b1;
         code_in       = code;
         total_in      = emit_total_in;
         last_in       = last;
         seq_in        = '0;
         if (code == scer_pkg::EV_SUMMARY) begin
            sum_count_in = scer_pkg::sat_inc32(sum_count_ff);
            seq_in       = sum_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         emit_total_ff <= '0;
         sum_count_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         idx_ff        <= idx_in;
         emit_total_ff <= emit_total_in;
         sum_count_ff  <= sum_count_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff  <= code_in;
      seq_ff   <= seq_in;
      total_ff <= total_in;
      last_ff  <= last_in;
   end

   assign rsp.valid            = out_valid_ff;
   assign rsp.event_code       = code_ff;
   assign rsp.summary_sequence = seq_ff;
   assign rsp.emitted_total    = total_ff;
   assign rsp.last_of_tick     = last_ff;

endmodule

// ===== src/status_change_event_reporter.sv =====
// Takes one observation per cycle while the two-entry tick queue has room; the
// front end works out the whole tick (summary due test, edge detection, event cap)
// in the cycle of the transfer. The back end sends the tick's items from the
// queue one per cycle, while the result port is ready, through a registered
// output; a tick has from one to seven items. The first item passes through the
// tick queue and then the output register before it is offered on the result
// port. Sustained rate is set by the result port: one item per cycle while it
// is ready. A write to the period register is taken in any cycle.
module status_change_event_reporter #(
   parameter int MAX_EVENTS = 6
) (
   input  logic       clock,
   input  logic       reset,
   scer_req_if.sink   req_bus,
   scer_rsp_if.source rsp_bus,
   scer_csr_if.sink   csr_bus
);

   logic                    q_push;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_empty;
   scer_pkg::tick_desc_type q_in_desc;
   scer_pkg::tick_desc_type q_head;

   scer_front #(
      .MAX_EVENTS (MAX_EVENTS)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_bus),
      .csr    (csr_bus),
      .q_full (q_full),
      .q_push (q_push),
      .q_desc (q_in_desc)
   );

   scer_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (q_in_desc),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   scer_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (q_head),
      .q_pop   (q_pop),
      .rsp     (rsp_bus)
   );

endmodule

// ===== src/scer_checker.sv =====
module scer_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [3:0]  event_code,
   input logic [31:0] summary_sequence,
   input logic [31:0] emitted_total,
   input logic        last_of_tick
);

   logic        xfer;
   logic        seen_ff, seen_in;
   logic [31:0] last_total_ff, last_total_in;

   assign xfer = rsp_valid && rsp_ready;

   always_comb begin
      seen_in       = seen_ff || xfer;
      last_total_in = xfer ? emitted_total : last_total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff       <= 1'b0;
         last_total_ff <= '0;
      end else begin
         seen_ff       <= seen_in;
         last_total_ff <= last_total_in;
      end
   end

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      xfer |-> emitted_total == (seen_ff ? scer_pkg::sat_inc32(last_total_ff) : 32'd1))
      else $error("emitted total out of step");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (event_code == scer_pkg::EV_SUMMARY) |-> last_of_tick)
      else $error("summary not last of tick");

   a_seq_only_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((event_code == scer_pkg::EV_SUMMARY) == (summary_sequence != 32'd0)))
      else $error("summary sequence on wrong item");

   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> event_code <= scer_pkg::EV_VIOLATION)
      else $error("event code out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(emitted_total))
      else $error("result dropped while stalled");

endmodule

bind status_change_event_reporter scer_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .event_code       (rsp_bus.event_code),
   .summary_sequence (rsp_bus.summary_sequence),
   .emitted_total    (rsp_bus.emitted_total),
   .last_of_tick     (rsp_bus.last_of_tick)
);

// ===== bench/status_change_event_reporter_tb.sv =====
module status_change_event_reporter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_EV = 6;

   typedef struct {
      logic [63:0]             time_us;
      logic                    net_rdy;
      logic                    link_avail;
      logic                    link_up;
      logic [7:0]              attempts;
      scer_pkg::src_state_type src_state;
      logic [15:0]             violation_mask;
   } tick_obs_type;

   typedef struct {
      scer_pkg::event_code_type code;
      logic [31:0]              sequence_no;
      logic [31:0]              total;
      logic                     last;
   } event_item_type;

   logic clock = 1'b0;
   logic reset;

   scer_req_if req_bus();
   scer_rsp_if rsp_bus();
   scer_csr_if csr_bus();

   status_change_event_reporter #(.MAX_EVENTS(MAX_EV)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   tick_obs_type   ticks_to_send[$];
   event_item_type items_due[$];
   int             queued_ticks = 0;
   int             accepted_ticks = 0;
   int             faults = 0;
   int             idle_pct = 27;

   // predictor state
   logic [31:0] period_cfg = scer_pkg::PERIOD_RESET;
   bit          seen_boot, seen_net, lnk_valid, lnk_prev_up, src_seen, viol_on;
   bit          summ_started;
   logic [7:0]  last_attempts = 8'd0;
   logic [3:0]  last_src = scer_pkg::SRC_UNCONFIGURED;
   logic [15:0] last_mask = 16'd0;
   logic [63:0] anchor = 64'd0;
   logic [31:0] summ_count = 32'd0;
   logic [31:0] item_total = 32'd0;

   // stimulus cursor
   logic [63:0] gen_time = 64'd0;
   logic [7:0]  gen_att = 8'd0;
   logic [3:0]  gen_src = scer_pkg::SRC_UNCONFIGURED;
   logic [15:0] gen_mask = 16'd0;
   logic        gen_link = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_fault(input string msg);
      faults++;
      $display("ERROR at %0t: %s", $time, msg);
   endtask

   function automatic bit source_event(input scer_pkg::src_state_type s,
                                       output scer_pkg::event_code_type c);
      bit has = 1'b1;
      c = scer_pkg::EV_BOOT;
      case (s)
         scer_pkg::SRC_UNCONFIGURED:  c = scer_pkg::EV_UNCONFIGURED;
         scer_pkg::SRC_START_PENDING: c = scer_pkg::EV_ATTEMPT;
         scer_pkg::SRC_SYNCING:       c = scer_pkg::EV_SYNCING;
         scer_pkg::SRC_TRUSTED:       c = scer_pkg::EV_TRUSTED;
         scer_pkg::SRC_REJECTED:      c = scer_pkg::EV_REJECTED;
         scer_pkg::SRC_TIMEOUT:       c = scer_pkg::EV_TIMEOUT;
         scer_pkg::SRC_ERROR:         c = scer_pkg::EV_ERROR;
         scer_pkg::SRC_INVALID:       c = scer_pkg::EV_INVALID;
         default:                     has = 1'b0;
      endcase
      return has;
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] v);
      return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
   endfunction

   // Works out the items one observation causes and queues them in order.
   function automatic void forecast_tick_items(input tick_obs_type o);
      scer_pkg::event_code_type evs[$];
      scer_pkg::event_code_type code;
      event_item_type           items[$];
      event_item_type           it;
      bit                       due;
      if (!summ_started) begin
         due = 1'b1;
      end else if (o.time_us < anchor) begin
         anchor = o.time_us;
         due = 1'b0;
      end else begin
         due = (o.time_us - anchor) >= {32'd0, period_cfg};
      end
      if (!seen_boot) begin
         seen_boot = 1'b1;
         evs.push_back(scer_pkg::EV_BOOT);
      end
      if (o.net_rdy && !seen_net) begin
         seen_net = 1'b1;
         evs.push_back(scer_pkg::EV_NET_READY);
      end
      if (o.link_avail) begin
         if (!lnk_valid || lnk_prev_up != o.link_up)
            evs.push_back(o.link_up ? scer_pkg::EV_LINK_READY : scer_pkg::EV_LINK_LOST);
         lnk_valid = 1'b1;
         lnk_prev_up = o.link_up;
      end
      if (o.attempts > last_attempts)
         evs.push_back(scer_pkg::EV_ATTEMPT);
      last_attempts = o.attempts;
      if (!src_seen || last_src != o.src_state) begin
         if (source_event(o.src_state, code))
            evs.push_back(code);
      end
      src_seen = 1'b1;
      last_src = o.src_state;
      if (o.violation_mask != 16'd0) begin
         if (!viol_on || last_mask != o.violation_mask || due)
            evs.push_back(scer_pkg::EV_VIOLATION);
         viol_on = 1'b1;
      end else begin
         viol_on = 1'b0;
      end
      last_mask = o.violation_mask;
      while (evs.size() > MAX_EV)
         void'(evs.pop_back());
      foreach (evs[i]) begin
         item_total = bump(item_total);
         it = '{evs[i], 32'd0, item_total, 1'b0};
         items.push_back(it);
      end
      if (due) begin
         summ_started = 1'b1;
         anchor = o.time_us;
         summ_count = bump(summ_count);
         item_total = bump(item_total);
         it = '{scer_pkg::EV_SUMMARY, summ_count, item_total, 1'b0};
         items.push_back(it);
      end
      foreach (items[i]) begin
         it = items[i];
         it.last = (i == items.size() - 1);
         items_due.push_back(it);
      end
   endfunction

   // request driver
   always @(posedge clock) begin : req_driver
      tick_obs_type o;
      tick_obs_type n;
      if (reset) begin
         req_bus.valid          <= 1'b0;
         req_bus.time_us        <= 64'd0;
         req_bus.net_rdy        <= 1'b0;
         req_bus.link_avail     <= 1'b0;
         req_bus.link_up        <= 1'b0;
         req_bus.attempts       <= 8'd0;
         req_bus.src_state      <= scer_pkg::SRC_UNCONFIGURED;
         req_bus.violation_mask <= 16'd0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            o = '{req_bus.time_us, req_bus.net_rdy, req_bus.link_avail, req_bus.link_up,
                  req_bus.attempts, req_bus.src_state, req_bus.violation_mask};
            forecast_tick_items(o);
            accepted_ticks++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (ticks_to_send.size() != 0 && $urandom_range(99) >= idle_pct) begin
               n = ticks_to_send.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.time_us        <= n.time_us;
               req_bus.net_rdy        <= n.net_rdy;
               req_bus.link_avail     <= n.link_avail;
               req_bus.link_up        <= n.link_up;
               req_bus.attempts       <= n.attempts;
               req_bus.src_state      <= n.src_state;
               req_bus.violation_mask <= n.violation_mask;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : rsp_monitor
      event_item_type e;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (items_due.size() == 0) begin
               flag_fault($sformatf("unexpected item, code %0d", rsp_bus.event_code));
            end else begin
               e = items_due.pop_front();
               if (rsp_bus.event_code !== e.code)
                  flag_fault($sformatf("event_code %0d, want %0d", rsp_bus.event_code, e.code));
               if (rsp_bus.summary_sequence !== e.sequence_no)
                  flag_fault($sformatf("summary_sequence %0d, want %0d",
                                       rsp_bus.summary_sequence, e.sequence_no));
               if (rsp_bus.emitted_total !== e.total)
                  flag_fault($sformatf("emitted_total %0d, want %0d",
                                       rsp_bus.emitted_total, e.total));
               if (rsp_bus.last_of_tick !== e.last)
                  flag_fault($sformatf("last_of_tick %0b, want %0b",
                                       rsp_bus.last_of_tick, e.last));
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic add_tick(input logic [63:0] t, input logic net, input logic lk,
                           input logic lu, input logic [7:0] att,
                           input scer_pkg::src_state_type src, input logic [15:0] mask);
      tick_obs_type o;
      o = '{t, net, lk, lu, att, src, mask};
      ticks_to_send.push_back(o);
      queued_ticks++;
   endtask

   task automatic settle();
      while (accepted_ticks != queued_ticks || items_due.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_period(input logic [31:0] v);
      @(posedge clock);
      csr_bus.valid             <= 1'b1;
      csr_bus.summary_period_us <= v;
      do @(posedge clock); while (!csr_bus.ready);
      period_cfg = v;
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_ticks(input int count);
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(19))
            0:          gen_time = gen_time - $urandom_range(1000);
            1:          gen_time = {$urandom, $urandom};
            2, 3, 4, 5: gen_time = gen_time + period_cfg + $urandom_range(3);
            default:    gen_time = gen_time + $urandom_range(period_cfg / 3);
         endcase
         case ($urandom_range(19))
            0, 1, 2:    gen_att = 8'($urandom);
            3, 4, 5, 6: gen_att = gen_att + 8'd1;
            7:          gen_att = gen_att - 8'd1;
            default:    ;
         endcase
         if ($urandom_range(9) < 3)
            gen_src = 4'($urandom_range(15));
         case ($urandom_range(19))
            0, 1, 2:       gen_mask = 16'd0;
            3, 4:          gen_mask = 16'd1 << $urandom_range(15);
            5, 6, 7, 8:    gen_mask = 16'($urandom);
            default:       ;
         endcase
         if ($urandom_range(3) == 0)
            gen_link = ~gen_link;
         add_tick(gen_time, $urandom_range(3) != 0, $urandom_range(4) != 0, gen_link,
                  gen_att, gen_src, gen_mask);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.summary_period_us = 32'd0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed, period at its reset value
      add_tick(64'd0, 1'b1, 1'b1, 1'b1, 8'd5, scer_pkg::SRC_START_PENDING, 16'hFFFF);
      add_tick(64'd10, 1'b1, 1'b1, 1'b0, 8'd5, scer_pkg::SRC_CONFIGURED, 16'hFFFF);
      add_tick(64'd20, 1'b0, 1'b0, 1'b1, 8'd5, scer_pkg::SRC_CONFIGURED, 16'hFFFF);
      add_tick(64'd30, 1'b1, 1'b1, 1'b1, 8'd255, scer_pkg::SRC_SYNCING, 16'h0001);
      add_tick(64'd40, 1'b1, 1'b1, 1'b1, 8'd0, scer_pkg::SRC_TRUSTED, 16'h0000);
      add_tick(64'd50, 1'b1, 1'b1, 1'b1, 8'd1, scer_pkg::SRC_REJECTED, 16'h8000);
      add_tick(64'd60, 1'b1, 1'b0, 1'b0, 8'd1, scer_pkg::SRC_TIMEOUT, 16'h8000);
      add_tick(64'd70, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_ERROR, 16'h5555);
      add_tick(64'd80, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_STOPPED, 16'hAAAA);
      add_tick(64'd90, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_INVALID, 16'hAAAA);
      add_tick(64'd100, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_RESERVED_FIRST, 16'hAAAA);
      add_tick(64'd110, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_RESERVED_LAST, 16'hAAAA);
      add_tick(64'd120, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_UNCONFIGURED, 16'hAAAA);
      add_tick(64'd60000000, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_UNCONFIGURED, 16'hAAAA);
      add_tick(64'd119999999, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_UNCONFIGURED, 16'hAAAA);
      add_tick(64'd5, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_UNCONFIGURED, 16'hAAAA);
      add_tick(64'd60000004, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_UNCONFIGURED, 16'hAAAA);
      add_tick(64'd60000005, 1'b1, 1'b1, 1'b0, 8'd1, scer_pkg::SRC_UNCONFIGURED, 16'hAAAA);
      add_tick(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'd2, scer_pkg::SRC_SYNCING,
               16'hFFFF);
      add_tick(64'd0, 1'b0, 1'b1, 1'b1, 8'd2, scer_pkg::SRC_SYNCING, 16'hFFFF);
      settle();

      write_period(32'd0);
      gen_time = 64'd1000;
      random_ticks(35);
      settle();

      write_period(32'd1);
      random_ticks(30);
      settle();

      // no idling on either side through this stretch
      idle_pct = 0;
      write_period(32'hFFFF_FFFF);
      random_ticks(30);
      settle();
      idle_pct = 27;

      write_period($urandom_range(100, 5000));
      random_ticks(20);
      settle();

      write_period($urandom);
      random_ticks(35);
      settle();

      if (items_due.size() != 0)
         flag_fault($sformatf("%0d items never arrived", items_due.size()));
      if (faults == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
